// ===== rtl/dpq_pkg.sv =====
package dpq_pkg;

  localparam int TAG_W           = 16;
  localparam int COORD_W         = 16;
  localparam int SQ_W            = 2 * COORD_W;
  localparam int PRIO_W          = 2 * COORD_W + 1;
  localparam int OCC_W           = 7;
  localparam int QUEUE_DEPTH_DEF = 64;
  localparam int FIFO_DEPTH      = 4;
  localparam int FIFO_PTR_W      = $clog2(FIFO_DEPTH);

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_t;

  typedef struct packed {
    op_t                        op;
    logic [TAG_W-1:0]           chunk_tag;
    logic signed [COORD_W-1:0]  chunk_x;
    logic signed [COORD_W-1:0]  chunk_z;
    logic signed [COORD_W-1:0]  center_x;
    logic signed [COORD_W-1:0]  center_z;
    logic                       chunk_unqueued;
  } in_item_t;

  typedef struct packed {
    logic                push_accepted;
    logic                popped_valid;
    logic [TAG_W-1:0]    popped_tag;
    logic [PRIO_W-1:0]   popped_priority;
    logic [OCC_W-1:0]    occupancy;
  } out_item_t;

  // Command handed from the front pipeline to the queue engine.
  typedef struct packed {
    op_t                 op;
    logic [TAG_W-1:0]    tag;
    logic                unqueued;
    logic [PRIO_W-1:0]   prio;
  } cmd_t;

endpackage

// ===== rtl/dpq_front.sv =====
module dpq_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  dpq_pkg::in_item_t  in_data,
  output logic               cmd_valid,
  input  logic               cmd_ready,
  output dpq_pkg::cmd_t      cmd
);

  typedef struct packed {
    dpq_pkg::op_t                  op;
    logic [dpq_pkg::TAG_W-1:0]     tag;
    logic                          unqueued;
    logic [dpq_pkg::COORD_W-1:0]   dx;
    logic [dpq_pkg::COORD_W-1:0]   dz;
  } dist_t;

  typedef struct packed {
    dpq_pkg::op_t                  op;
    logic [dpq_pkg::TAG_W-1:0]     tag;
    logic                          unqueued;
    logic [dpq_pkg::SQ_W-1:0]      dx_sq;
    logic [dpq_pkg::SQ_W-1:0]      dz_sq;
  } square_t;

  function automatic logic [dpq_pkg::COORD_W-1:0] abs_diff(
    input logic signed [dpq_pkg::COORD_W-1:0] a,
    input logic signed [dpq_pkg::COORD_W-1:0] b
  );
    logic [dpq_pkg::COORD_W:0] d;
    logic [dpq_pkg::COORD_W:0] nd;
    d  = {a[dpq_pkg::COORD_W-1], a} - {b[dpq_pkg::COORD_W-1], b};
    nd = -d;
    return d[dpq_pkg::COORD_W] ? nd[dpq_pkg::COORD_W-1:0] : d[dpq_pkg::COORD_W-1:0];
  endfunction

  logic    dist_v_r;
  dist_t   dist_r;
  dist_t   dist_nxt;
  logic    sq_v_r;
  square_t sq_r;
  square_t sq_nxt;
  logic    sq_adv;
  logic    dist_adv;

  assign sq_adv   = !sq_v_r || cmd_ready;
  assign dist_adv = !dist_v_r || sq_adv;
  assign in_ready = dist_adv;

  always_comb begin
    dist_nxt.op       = in_data.op;
    dist_nxt.tag      = in_data.chunk_tag;
    dist_nxt.unqueued = in_data.chunk_unqueued;
    dist_nxt.dx       = abs_diff(in_data.chunk_x, in_data.center_x);
    dist_nxt.dz       = abs_diff(in_data.chunk_z, in_data.center_z);
  end

  always_comb begin
    sq_nxt.op       = dist_r.op;
    sq_nxt.tag      = dist_r.tag;
    sq_nxt.unqueued = dist_r.unqueued;
    sq_nxt.dx_sq    = dpq_pkg::SQ_W'(dist_r.dx) * dpq_pkg::SQ_W'(dist_r.dx);
    sq_nxt.dz_sq    = dpq_pkg::SQ_W'(dist_r.dz) * dpq_pkg::SQ_W'(dist_r.dz);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_v_r <= 1'b0;
      sq_v_r   <= 1'b0;
    end else begin
      if (dist_adv) begin
        dist_v_r <= in_valid;
      end
      if (sq_adv) begin
        sq_v_r <= dist_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dist_adv && in_valid) begin
      dist_r <= dist_nxt;
    end
    if (sq_adv && dist_v_r) begin
      sq_r <= sq_nxt;
    end
  end

  assign cmd_valid    = sq_v_r;
  assign cmd.op       = sq_r.op;
  assign cmd.tag      = sq_r.tag;
  assign cmd.unqueued = sq_r.unqueued;
  assign cmd.prio     = dpq_pkg::PRIO_W'(sq_r.dx_sq) + dpq_pkg::PRIO_W'(sq_r.dz_sq);

endmodule

// ===== rtl/dpq_fifo.sv =====
module dpq_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  dpq_pkg::cmd_t  wr_data,
  output logic           rd_valid,
  input  logic           rd_ready,
  output dpq_pkg::cmd_t  rd_data
);

  localparam int CNT_W = dpq_pkg::FIFO_PTR_W + 1;

  dpq_pkg::cmd_t                   mem_r [dpq_pkg::FIFO_DEPTH];
  logic [dpq_pkg::FIFO_PTR_W-1:0]  wp_r;
  logic [dpq_pkg::FIFO_PTR_W-1:0]  rp_r;
  logic [CNT_W-1:0]                count_r;
  logic [CNT_W-1:0]                count_nxt;
  logic                            wr_fire;
  logic                            rd_fire;

  assign wr_ready = count_r != CNT_W'(dpq_pkg::FIFO_DEPTH);
  assign rd_valid = count_r != '0;
  assign rd_data  = mem_r[rp_r];
  assign wr_fire  = wr_valid && wr_ready;
  assign rd_fire  = rd_valid && rd_ready;

  always_comb begin
    count_nxt = count_r;
    if (wr_fire && !rd_fire) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (rd_fire && !wr_fire) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
      if (wr_fire) begin
        wp_r <= wp_r + dpq_pkg::FIFO_PTR_W'(1);
      end
      if (rd_fire) begin
        rp_r <= rp_r + dpq_pkg::FIFO_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_fire) begin
      mem_r[wp_r] <= wr_data;
    end
  end

endmodule

// ===== rtl/dpq_back.sv =====
module dpq_back #(
  parameter int QUEUE_DEPTH = dpq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  dpq_pkg::cmd_t      cmd,
  output logic               out_valid,
  input  logic               out_ready,
  output dpq_pkg::out_item_t out_data
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [dpq_pkg::TAG_W-1:0]  tag_r     [QUEUE_DEPTH];
  logic [dpq_pkg::PRIO_W-1:0] prio_r    [QUEUE_DEPTH];
  logic [dpq_pkg::TAG_W-1:0]  tag_nxt   [QUEUE_DEPTH];
  logic [dpq_pkg::PRIO_W-1:0] prio_nxt  [QUEUE_DEPTH];
  logic [dpq_pkg::TAG_W-1:0]  prev_tag  [QUEUE_DEPTH];
  logic [dpq_pkg::PRIO_W-1:0] prev_prio [QUEUE_DEPTH];
  logic [dpq_pkg::TAG_W-1:0]  next_tag  [QUEUE_DEPTH];
  logic [dpq_pkg::PRIO_W-1:0] next_prio [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]     later;
  logic [QUEUE_DEPTH-1:0]     later_prev;

  logic [CNT_W-1:0]    count_r;
  logic [CNT_W-1:0]    count_nxt;
  logic                out_valid_r;
  dpq_pkg::out_item_t  out_r;
  dpq_pkg::out_item_t  out_nxt;
  logic                take;
  logic                full;
  logic                empty;
  logic                do_push;
  logic                do_pop;

  assign cmd_ready = !out_valid_r || out_ready;
  assign take      = cmd_valid && cmd_ready;
  assign full      = count_r == CNT_W'(QUEUE_DEPTH);
  assign empty     = count_r == '0;
  assign do_push   = take && (cmd.op == dpq_pkg::OP_PUSH) && cmd.unqueued && !full;
  assign do_pop    = take && (cmd.op == dpq_pkg::OP_POP) && !empty;

  // Each cell flags whether the new task belongs in front of it; free cells always do.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    assign later[i] = (CNT_W'(i) >= count_r) || (prio_r[i] > cmd.prio);
    if (i == 0) begin : g_head
      assign later_prev[i] = 1'b0;
      assign prev_tag[i]   = '0;
      assign prev_prio[i]  = '0;
    end else begin : g_body
      assign later_prev[i] = later[i-1];
      assign prev_tag[i]   = tag_r[i-1];
      assign prev_prio[i]  = prio_r[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign next_tag[i]  = tag_r[i];
      assign next_prio[i] = prio_r[i];
    end else begin : g_inner
      assign next_tag[i]  = tag_r[i+1];
      assign next_prio[i] = prio_r[i+1];
    end
  end

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      tag_nxt[i]  = tag_r[i];
      prio_nxt[i] = prio_r[i];
      if (do_push) begin
        if (later_prev[i]) begin
          tag_nxt[i]  = prev_tag[i];
          prio_nxt[i] = prev_prio[i];
        end else if (later[i]) begin
          tag_nxt[i]  = cmd.tag;
          prio_nxt[i] = cmd.prio;
        end
      end else if (do_pop) begin
        tag_nxt[i]  = next_tag[i];
        prio_nxt[i] = next_prio[i];
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (do_push) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_comb begin
    out_nxt.push_accepted   = do_push;
    out_nxt.popped_valid    = do_pop;
    out_nxt.popped_tag      = do_pop ? tag_r[0] : '0;
    out_nxt.popped_priority = do_pop ? prio_r[0] : '0;
    out_nxt.occupancy       = dpq_pkg::OCC_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (take) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_r <= out_nxt;
    end
    if (do_push || do_pop) begin
      tag_r  <= tag_nxt;
      prio_r <= prio_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count above queue depth");

  a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    count_r >= CNT_W'(2) |-> prio_r[0] <= prio_r[1])
    else $error("head entries out of priority order");

  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !take |=> $stable(count_r))
    else $error("entry count moved without a command");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> $stable(count_r))
    else $error("queue advanced while result was stalled");

  a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
    take && (cmd.op == dpq_pkg::OP_PUSH) && full |=> !out_r.push_accepted)
    else $error("push accepted into a full queue");

endmodule

// ===== rtl/distance_priority_task_queue.sv =====
// Channel | Ports                          | Transaction
// input   | in_valid, in_ready, in_data    | one push or pop command
// result  | out_valid, out_ready, out_data | one status / popped entry per command
//
// Sustains one transaction per cycle while out_ready is high; a command passes the difference
// and square registers and the command queue before its result is loaded into the result register.
// Path of a command: two front stages (coordinate differences, squares), the 4-entry command
// queue, and the update of the sorted cell row, which also loads the result register.
// Reset (rst_n low, synchronous) empties the queue at once; no clearing pass is needed.
// out_ready low holds the result register, then fills the command queue and the front
// stages, after which in_ready drops.
module distance_priority_task_queue #(
  parameter int QUEUE_DEPTH = dpq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  dpq_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output dpq_pkg::out_item_t out_data
);

  logic          fr_valid;
  logic          fr_ready;
  dpq_pkg::cmd_t fr_cmd;
  logic          bk_valid;
  logic          bk_ready;
  dpq_pkg::cmd_t bk_cmd;

  dpq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cmd_valid (fr_valid),
    .cmd_ready (fr_ready),
    .cmd       (fr_cmd)
  );

  dpq_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fr_valid),
    .wr_ready (fr_ready),
    .wr_data  (fr_cmd),
    .rd_valid (bk_valid),
    .rd_ready (bk_ready),
    .rd_data  (bk_cmd)
  );

  dpq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (bk_valid),
    .cmd_ready (bk_ready),
    .cmd       (bk_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== test/dpq_result_checker.sv =====
module dpq_result_checker #(
  parameter int QUEUE_DEPTH = dpq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  dpq_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  dpq_pkg::out_item_t out_data,
  output int                 mismatch_count,
  output int                 pending_count
);
  import dpq_pkg::*;

  // Scheduled tasks, head first, kept sorted by ascending squared distance.
  logic [TAG_W-1:0]  held_tag[$];
  logic [PRIO_W-1:0] held_prio[$];
  out_item_t         expected_status[$];

  function automatic logic [PRIO_W-1:0] squared_distance(input in_item_t cmd);
    longint dx;
    longint dz;
    dx = longint'($signed(cmd.chunk_x)) - longint'($signed(cmd.center_x));
    dz = longint'($signed(cmd.chunk_z)) - longint'($signed(cmd.center_z));
    return PRIO_W'(dx * dx + dz * dz);
  endfunction

  function automatic out_item_t schedule_command(input in_item_t cmd);
    out_item_t         res;
    logic [PRIO_W-1:0] prio;
    int                pos;
    res = '0;
    if (cmd.op == OP_PUSH) begin
      if (held_prio.size() < QUEUE_DEPTH && cmd.chunk_unqueued) begin
        prio = squared_distance(cmd);
        // Insert behind every entry of equal priority to keep arrival order.
        pos = 0;
        while (pos < held_prio.size() && held_prio[pos] <= prio) pos++;
        held_prio.insert(pos, prio);
        held_tag.insert(pos, cmd.chunk_tag);
        res.push_accepted = 1'b1;
      end
    end else if (held_prio.size() != 0) begin
      res.popped_valid    = 1'b1;
      res.popped_tag      = held_tag.pop_front();
      res.popped_priority = held_prio.pop_front();
    end
    res.occupancy = OCC_W'(held_prio.size());
    return res;
  endfunction

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      held_tag.delete();
      held_prio.delete();
      expected_status.delete();
      mismatch_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_status.size() == 0) begin
          if (mismatch_count < 10)
            $display("unexpected result: acc=%0b vld=%0b tag=%h prio=%0d occ=%0d",
                     out_data.push_accepted, out_data.popped_valid, out_data.popped_tag,
                     out_data.popped_priority, out_data.occupancy);
          mismatch_count++;
        end else begin
          want = expected_status.pop_front();
          if (out_data.push_accepted !== want.push_accepted ||
              out_data.popped_valid !== want.popped_valid ||
              out_data.popped_tag !== want.popped_tag ||
              out_data.popped_priority !== want.popped_priority ||
              out_data.occupancy !== want.occupancy) begin
            if (mismatch_count < 10)
              $display({"bad result: expected acc=%0b vld=%0b tag=%h prio=%0d occ=%0d,",
                        " got acc=%0b vld=%0b tag=%h prio=%0d occ=%0d"},
                       want.push_accepted, want.popped_valid, want.popped_tag,
                       want.popped_priority, want.occupancy,
                       out_data.push_accepted, out_data.popped_valid, out_data.popped_tag,
                       out_data.popped_priority, out_data.occupancy);
            mismatch_count++;
          end
        end
      end
      if (in_valid && in_ready)
        expected_status.push_back(schedule_command(in_data));
    end
    pending_count = expected_status.size();
  end

endmodule

// ===== test/tb_distance_priority_task_queue.sv =====
module tb_distance_priority_task_queue;
  import dpq_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  int        mismatch_count;
  int        pending_count;

  int send_idle_pct;
  int recv_stall_pct;
  int phase_send_pct[4]  = '{0, 83, 0, 6};
  int phase_stall_pct[4] = '{0, 0, 83, 6};

  distance_priority_task_queue u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  dpq_result_checker u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("distance_priority_task_queue: mismatch");
    $finish;
  end

  // Drop ready at random per the current stall rate.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic logic [COORD_W-1:0] rand_coord();
    int v;
    case ($urandom_range(3))
      0: return COORD_W'($urandom);
      1: begin
        case ($urandom_range(3))
          0: return {1'b1, {(COORD_W-1){1'b0}}};
          1: return {1'b0, {(COORD_W-1){1'b1}}};
          2: return '0;
          default: return '1;
        endcase
      end
      default: begin
        // Small spread around the origin makes equal priorities common.
        v = int'($urandom_range(8)) - 4;
        return COORD_W'(v);
      end
    endcase
  endfunction

  function automatic in_item_t make_push(input logic [TAG_W-1:0] tag,
                                         input int cx, input int cz,
                                         input int ox, input int oz,
                                         input logic unqueued);
    in_item_t t;
    t.op             = OP_PUSH;
    t.chunk_tag      = tag;
    t.chunk_x        = COORD_W'(cx);
    t.chunk_z        = COORD_W'(cz);
    t.center_x       = COORD_W'(ox);
    t.center_z       = COORD_W'(oz);
    t.chunk_unqueued = unqueued;
    return t;
  endfunction

  function automatic in_item_t rand_push(input bit always_unqueued);
    in_item_t t;
    t.op             = OP_PUSH;
    t.chunk_tag      = TAG_W'($urandom);
    t.chunk_x        = rand_coord();
    t.chunk_z        = rand_coord();
    t.center_x       = rand_coord();
    t.center_z       = rand_coord();
    t.chunk_unqueued = always_unqueued || ($urandom_range(9) != 0);
    return t;
  endfunction

  // Pops carry random payload bits, which the block must ignore.
  function automatic in_item_t make_pop();
    in_item_t t;
    t                = rand_push(1'b0);
    t.op             = OP_POP;
    t.chunk_unqueued = 1'($urandom_range(1));
    return t;
  endfunction

  task automatic send_cmd(input in_item_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic run_random(input int count);
    int done;
    int burst_len;
    int push_pct;
    done = 0;
    while (done < count) begin
      burst_len = $urandom_range(80, 10);
      case ($urandom_range(2))
        0:       push_pct = 85;
        1:       push_pct = 15;
        default: push_pct = 55;
      endcase
      repeat (burst_len) begin
        if ($urandom_range(99) < push_pct) send_cmd(rand_push(1'b0));
        else send_cmd(make_pop());
        done++;
      end
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty pop, distance extremes, ties, rejected push.
    send_cmd(make_pop());
    send_cmd(make_push(16'hFFFF, -32768, -32768, 32767, 32767, 1'b1));
    send_cmd(make_push(16'h0000, 0, 0, 0, 0, 1'b1));
    send_cmd(make_push(16'h1234, 32767, 32767, -32768, -32768, 1'b1));
    send_cmd(make_push(16'h00AA, 5, -7, 5, -7, 1'b1));
    send_cmd(make_push(16'hBEEF, 1, 1, 0, 0, 1'b0));
    send_cmd(make_push(16'h5555, 3, 4, 0, 0, 1'b1));
    send_cmd(make_push(16'hAAAA, -3, -4, 0, 0, 1'b1));
    send_cmd(make_push(16'h0F0F, 1, 0, 0, 0, 1'b1));
    repeat (8) send_cmd(make_pop());
    send_cmd(make_push(16'hC3C3, -1, -1, 0, 0, 1'b1));
    send_cmd(make_pop());

    // Fill past capacity, then drain past empty.
    repeat (66) send_cmd(rand_push(1'b1));
    repeat (66) send_cmd(make_pop());

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = phase_send_pct[p];
      recv_stall_pct = phase_stall_pct[p];
      run_random(290);
    end

    in_valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("distance_priority_task_queue: match");
    end else begin
      $display("distance_priority_task_queue: mismatch");
    end
    $finish;
  end

endmodule

// ===== distance_priority_task_queue.f =====
rtl/dpq_pkg.sv
rtl/dpq_front.sv
rtl/dpq_fifo.sv
rtl/dpq_back.sv
rtl/distance_priority_task_queue.sv
test/dpq_result_checker.sv
test/tb_distance_priority_task_queue.sv
